// ===== rtl/core/binary_content_detector_assert.svh =====
// Assertion helpers for the binary content detector.
// Both forms sample on i_clk and stay quiet while i_rst_n is low.
`ifndef BINARY_CONTENT_DETECTOR_ASSERT_SVH
`define BINARY_CONTENT_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define BCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bcd_pkg.sv =====
`timescale 1ns / 1ps

package bcd_pkg;

    localparam int unsigned CAUSE_W = 3;
    localparam int unsigned TOTAL_W = 10;

    typedef logic [CAUSE_W-1:0] t_cause;

    localparam t_cause CAUSE_EMPTY      = 3'd0;
    localparam t_cause CAUSE_UTF8_MARK  = 3'd1;
    localparam t_cause CAUSE_PDF_HEADER = 3'd2;
    localparam t_cause CAUSE_ZERO_BYTE  = 3'd3;
    localparam t_cause CAUSE_RATIO_BIN  = 3'd4;
    localparam t_cause CAUSE_RATIO_TEXT = 3'd5;

    localparam int unsigned MARK_LEN = 3;
    localparam int unsigned PDF_LEN  = 5;

    // Expected byte of the UTF-8 byte order mark at a given offset.
    function automatic logic [7:0] mark_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hEF;
            2'd1:    b = 8'hBB;
            default: b = 8'hBF;
        endcase
        return b;
    endfunction

    // Expected byte of the "%PDF-" header at a given offset.
    function automatic logic [7:0] pdf_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h25;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h44;
            3'd3:    b = 8'h46;
            default: b = 8'h2D;
        endcase
        return b;
    endfunction

    // Control bytes 0-5 and 15-31, stray continuation bytes and lead bytes of 240 and up.
    function automatic logic odd_byte(input logic [7:0] b);
        return (b <= 8'd5) || (b >= 8'd15 && b <= 8'd31) ||
               (b >= 8'd128 && b <= 8'd191) || (b >= 8'd240);
    endfunction

endpackage

// ===== rtl/core/binary_content_detector.sv =====
`timescale 1ns / 1ps
// Path: a closing item accepted into the input register passes the update logic and
//   then the result register behind o_out_valid; an occupied result slot can hold it back.
// Throughput: one item per cycle; the single per-byte update of the counters is
//   the only work, so nothing but a stalled output slot holds the input back.
// Reset (synchronous, i_rst_n low): both valid flags drop and all buffer state
//   returns to its start values; no clearing pass is needed.

`include "binary_content_detector_assert.svh"

module binary_content_detector #(
    parameter int unsigned SAMPLE_LIMIT = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_carries_byte,
    input  logic                          i_last,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_binary,
    output bcd_pkg::t_cause               o_cause,
    output logic [bcd_pkg::TOTAL_W-1:0]   o_suspicious_total
);

    // Byte counter saturates at SAMPLE_LIMIT, so it needs room for that value.
    localparam int unsigned SeenW = $clog2(SAMPLE_LIMIT + 1);
    // count*10 needs four more bits than the count.
    localparam int unsigned CmpW  = SeenW + 4;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_carries;
    logic       r_in_last;

    // ------------------------------------------------------------------
    // Per-buffer state
    // ------------------------------------------------------------------
    logic [SeenW-1:0] r_seen,   n_seen;
    logic [SeenW-1:0] r_count,  n_count;
    logic [1:0]       r_pend,   n_pend;
    logic             r_malf,   n_malf;
    logic             r_zero,   n_zero;
    logic             r_mark,   n_mark;
    logic             r_pdf,    n_pdf;

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                        r_out_valid;
    logic                        r_out_binary,  n_out_binary;
    bcd_pkg::t_cause             r_out_cause,   n_out_cause;
    logic [bcd_pkg::TOTAL_W-1:0] r_out_total,   n_out_total;

    logic             out_free;
    logic             advance;
    logic [CmpW-1:0]  count_x10;
    logic             ratio_bin;

    // Terms for the checks at the end.
    logic             chk_text_out;
    logic             chk_fixed_out;
    logic             chk_counts_ok;
    logic             chk_verdict;
    logic             chk_state_clear;

    // A buffered item moves on unless it closes a buffer and the result
    // slot is still occupied.
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_in_ready = !r_in_valid || advance;

    // Take one byte into the running state.
    always_comb begin
        n_seen  = r_seen;
        n_count = r_count;
        n_pend  = r_pend;
        n_malf  = r_malf;
        n_zero  = r_zero;
        n_mark  = r_mark;
        n_pdf   = r_pdf;

        if (r_in_carries) begin
            // Header matching only looks at the leading bytes.
            if (r_seen < SeenW'(bcd_pkg::MARK_LEN) &&
                r_in_byte != bcd_pkg::mark_byte(r_seen[1:0])) begin
                n_mark = 1'b0;
            end
            if (r_seen < SeenW'(bcd_pkg::PDF_LEN) &&
                r_in_byte != bcd_pkg::pdf_byte(r_seen[2:0])) begin
                n_pdf = 1'b0;
            end

            // Past the sample the length is already saturated: drop the byte.
            if (r_seen < SeenW'(SAMPLE_LIMIT)) begin
                if (r_in_byte == 8'd0) begin
                    n_zero = 1'b1;
                end
                if (r_pend != 2'd0) begin
                    // Continuation byte of a multibyte group.
                    n_malf = r_malf || (r_in_byte[7:6] != 2'b10);
                    n_pend = r_pend - 2'd1;
                    if (n_pend == 2'd0 && n_malf) begin
                        n_count = r_count + SeenW'(1);
                    end
                end else if (r_in_byte >= 8'd192 && r_in_byte < 8'd224) begin
                    n_pend = 2'd1;
                    n_malf = 1'b0;
                end else if (r_in_byte >= 8'd224 && r_in_byte < 8'd240) begin
                    n_pend = 2'd2;
                    n_malf = 1'b0;
                end else if (bcd_pkg::odd_byte(r_in_byte)) begin
                    n_count = r_count + SeenW'(1);
                end
                n_seen = r_seen + SeenW'(1);
            end
        end
    end

    // count*10 as two shifts and one add.
    assign count_x10 = (CmpW'(n_count) << 3) + (CmpW'(n_count) << 1);
    assign ratio_bin = count_x10 > CmpW'(n_seen);

    // Verdict in priority order, taken from the state after this item.
    always_comb begin
        n_out_binary = 1'b0;
        n_out_total  = '0;
        if (n_seen == '0) begin
            n_out_cause = bcd_pkg::CAUSE_EMPTY;
        end else if (n_mark && n_seen >= SeenW'(bcd_pkg::MARK_LEN)) begin
            n_out_cause = bcd_pkg::CAUSE_UTF8_MARK;
        end else if (n_pdf && n_seen >= SeenW'(bcd_pkg::PDF_LEN)) begin
            n_out_binary = 1'b1;
            n_out_cause  = bcd_pkg::CAUSE_PDF_HEADER;
        end else if (n_zero) begin
            n_out_binary = 1'b1;
            n_out_cause  = bcd_pkg::CAUSE_ZERO_BYTE;
        end else begin
            n_out_total = bcd_pkg::TOTAL_W'(n_count);
            if (ratio_bin) begin
                n_out_binary = 1'b1;
                n_out_cause  = bcd_pkg::CAUSE_RATIO_BIN;
            end else begin
                n_out_cause  = bcd_pkg::CAUSE_RATIO_TEXT;
            end
        end
    end

    // Input register: load whenever the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte    <= i_data_byte;
            r_in_carries <= i_carries_byte;
            r_in_last    <= i_last;
        end
    end

    // Buffer state: advance on each processed item, clear after a verdict.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            r_seen  <= '0;
            r_count <= '0;
            r_pend  <= 2'd0;
            r_malf  <= 1'b0;
            r_zero  <= 1'b0;
            r_mark  <= 1'b1;
            r_pdf   <= 1'b1;
        end else if (advance) begin
            r_seen  <= n_seen;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_malf  <= n_malf;
            r_zero  <= n_zero;
            r_mark  <= n_mark;
            r_pdf   <= n_pdf;
        end
    end

    // Result register: hold until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_binary <= n_out_binary;
            r_out_cause  <= n_out_cause;
            r_out_total  <= n_out_total;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_binary           = r_out_binary;
    assign o_cause            = r_out_cause;
    assign o_suspicious_total = r_out_total;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    assign chk_text_out    = o_out_valid && (o_cause == bcd_pkg::CAUSE_EMPTY ||
                                             o_cause == bcd_pkg::CAUSE_UTF8_MARK ||
                                             o_cause == bcd_pkg::CAUSE_RATIO_TEXT);
    assign chk_fixed_out   = o_out_valid && o_cause != bcd_pkg::CAUSE_RATIO_BIN &&
                             o_cause != bcd_pkg::CAUSE_RATIO_TEXT;
    assign chk_counts_ok   = r_count <= r_seen && r_seen <= SeenW'(SAMPLE_LIMIT);
    assign chk_verdict     = advance && r_in_last;
    assign chk_state_clear = r_seen == '0 && r_pend == 2'd0 && r_mark && r_pdf;

    `BCD_ASSERT_NOW(a_text_causes, chk_text_out, !o_binary, "binary verdict on text cause")
    `BCD_ASSERT_NOW(a_total_only_ratio, chk_fixed_out, o_suspicious_total == '0, "stray count")
    `BCD_ASSERT_NOW(a_count_bounds, 1'b1, chk_counts_ok, "counter out of range")
    `BCD_ASSERT_NEXT(a_clear_after_verdict, chk_verdict, chk_state_clear, "state not cleared")

endmodule
